// File: hw/rtl/dpsm_pkg.sv
`default_nettype none

package dpsm_pkg;

	localparam int unsigned OP_W       = 2;
	localparam int unsigned CW_W       = 16;
	localparam int unsigned MODE_W     = 8;
	localparam int unsigned STATUS_W   = 16;
	localparam int unsigned STATE_W    = 3;
	localparam int unsigned REASON_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned QSO_W      = 16;

	// request kinds
	localparam logic [OP_W-1:0] OP_CTRL = 2'd0;
	localparam logic [OP_W-1:0] OP_MODE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPORTED_MODES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QS_OPTION       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REMOTE          = 2'd2;

	// controlword decode
	localparam int unsigned       CW_FAULT_RESET_BIT = 7;
	localparam logic [CW_W-1:0]   CW_CMD_MASK        = 16'h008F;
	localparam logic [CW_W-1:0]   CW_DISABLE_VOLTAGE = 16'h0000;
	localparam logic [CW_W-1:0]   CW_SHUTDOWN        = 16'h0006;
	localparam logic [CW_W-1:0]   CW_SWITCH_ON       = 16'h0007;
	localparam logic [CW_W-1:0]   CW_ENABLE_OP       = 16'h000F;
	localparam logic [CW_W-1:0]   CW_QUICK_STOP      = 16'h0002;

	localparam logic [STATUS_W-1:0] STATUS_RESET = 16'h0240;

	localparam logic [REASON_W-1:0] REASON_NONE    = 2'd0;
	localparam logic [REASON_W-1:0] REASON_UNSUP   = 2'd1;
	localparam logic [REASON_W-1:0] REASON_HANDLER = 2'd2;

	localparam logic signed [QSO_W-1:0] QSO_RESET   = 16'sd2;
	localparam logic signed [QSO_W-1:0] QSO_SOD_MAX = 16'sd2;

	// operating modes with handlers
	localparam logic [4:0] MODE_PROFILE_POS = 5'd1;
	localparam logic [4:0] MODE_VELOCITY    = 5'd2;
	localparam logic [4:0] MODE_PROFILE_VEL = 5'd3;
	localparam logic [4:0] MODE_TORQUE      = 5'd4;
	localparam logic [4:0] MODE_HOMING      = 5'd6;
	localparam logic [4:0] MODE_INTERP_POS  = 5'd7;
	localparam logic [4:0] MODE_CSP         = 5'd8;
	localparam logic [4:0] MODE_CSV         = 5'd9;
	localparam logic [4:0] MODE_CST         = 5'd10;

endpackage

`default_nettype wire

// File: hw/rtl/dpsm_in_if.sv
`default_nettype none

interface dpsm_in_if import dpsm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic [CW_W-1:0]          control_value;
	logic signed [MODE_W-1:0] mode_value;
	logic                     handler_present;
	logic                     handler_ok;

	modport source (
		output valid, op, control_value, mode_value, handler_present, handler_ok,
		input  ready
	);
	modport sink (
		input  valid, op, control_value, mode_value, handler_present, handler_ok,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/dpsm_out_if.sv
`default_nettype none

interface dpsm_out_if import dpsm_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status_word;
	logic signed [MODE_W-1:0] mode_shown;
	logic [STATE_W-1:0]       drive_state;
	logic [REASON_W-1:0]      fault_reason;
	logic                     fault_active;

	modport source (
		output valid, status_word, mode_shown, drive_state, fault_reason, fault_active,
		input  ready
	);
	modport sink (
		input  valid, status_word, mode_shown, drive_state, fault_reason, fault_active,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/dpsm_cfg_if.sv
`default_nettype none

interface dpsm_cfg_if import dpsm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/drive_power_state_machine.sv
// Results are registered; a request accepted at an edge has its result valid after that edge.
// Throughput: one request per cycle; the state registers double as the result register,
// so a new request is taken whenever the result is empty or being taken in the same cycle.
// Reset (arst_n low, asynchronous): switch on disabled, statusword 0x0240, flags and
// mode cleared, supported modes 0, quick stop option 2, remote 1, no result pending.
`default_nettype none

module drive_power_state_machine import dpsm_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	dpsm_in_if.sink     item,
	dpsm_out_if.source  result,
	dpsm_cfg_if.sink    cfg
);

	typedef enum logic [STATE_W-1:0] {
		ST_SOD  = 3'd0,
		ST_RDY  = 3'd1,
		ST_SWON = 3'd2,
		ST_OPEN = 3'd3,
		ST_QS   = 3'd4,
		ST_FRA  = 3'd5,
		ST_FLT  = 3'd6
	} state_t;

	typedef enum logic [2:0] {
		CMD_NONE, CMD_DV, CMD_SD, CMD_SO, CMD_DO, CMD_EO, CMD_QS, CMD_FR
	} cmd_t;

	state_t                   state_q;
	logic signed [MODE_W-1:0] mode_q;
	logic signed [MODE_W-1:0] mode_latched_q;
	logic                     warn_q;
	logic                     reached_q;
	logic                     limit_q;
	logic [REASON_W-1:0]      reason_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     out_valid_q;

	logic [CFG_DATA_W-1:0]    sup_modes_q;
	logic signed [QSO_W-1:0]  qso_q;
	logic                     remote_q;

	state_t                   nxt_state;
	logic signed [MODE_W-1:0] nxt_mode;
	logic                     nxt_warn;
	logic                     nxt_reached;
	logic                     nxt_limit;
	logic [REASON_W-1:0]      nxt_reason;
	logic                     rebuild;
	cmd_t                     cmd;
	logic [CW_W-1:0]          cw_masked;
	logic                     mode_sup;
	logic [6:0]               state_bits;
	logic [STATUS_W-1:0]      nxt_status;
	logic                     accept;

	assign item.ready = !out_valid_q || result.ready;
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;

	assign cw_masked = item.control_value & CW_CMD_MASK;
	assign mode_sup  = !mode_q[MODE_W-1] && (mode_q[6:5] == 2'b00)
		&& sup_modes_q[mode_q[4:0]];

	always_comb begin
		nxt_state   = state_q;
		nxt_mode    = mode_q;
		nxt_warn    = warn_q;
		nxt_reached = reached_q;
		nxt_limit   = limit_q;
		nxt_reason  = reason_q;
		rebuild     = 1'b0;
		cmd         = CMD_NONE;

		case (item.op)
			OP_CTRL: begin
				if (item.control_value[CW_FAULT_RESET_BIT]) begin
					cmd = CMD_FR;
				end else if (cw_masked == CW_DISABLE_VOLTAGE) begin
					cmd = CMD_DV;
				end else if (cw_masked == CW_SHUTDOWN) begin
					cmd = CMD_SD;
				end else if (cw_masked == CW_SWITCH_ON) begin
					cmd = (state_q == ST_OPEN) ? CMD_DO : CMD_SO;
				end else if (cw_masked == CW_ENABLE_OP) begin
					cmd = CMD_EO;
				end else if (cw_masked == CW_QUICK_STOP) begin
					cmd = CMD_QS;
				end

				case (state_q)
					ST_SOD: begin
						if (cmd == CMD_SD) nxt_state = ST_RDY;
					end
					ST_RDY: begin
						if (cmd == CMD_DV || cmd == CMD_QS) nxt_state = ST_SOD;
						else if (cmd == CMD_SO) nxt_state = ST_SWON;
					end
					ST_SWON: begin
						if (cmd == CMD_SD) nxt_state = ST_RDY;
						else if (cmd == CMD_DV || cmd == CMD_QS) nxt_state = ST_SOD;
						else if (cmd == CMD_EO) nxt_state = ST_OPEN;
					end
					ST_OPEN: begin
						if (cmd == CMD_DO) nxt_state = ST_SWON;
						else if (cmd == CMD_SD) nxt_state = ST_RDY;
						else if (cmd == CMD_DV) nxt_state = ST_SOD;
						else if (cmd == CMD_QS) nxt_state = ST_QS;
					end
					ST_QS: begin
						if (cmd == CMD_DV) nxt_state = ST_SOD;
						else if (cmd == CMD_EO) nxt_state = ST_OPEN;
					end
					ST_FLT: begin
						if (cmd == CMD_FR) nxt_state = ST_SOD;
					end
					default: ;
				endcase

				// quick stop options 0..2 end in switch on disabled
				if (nxt_state == ST_QS) begin
					if (qso_q >= 16'sd0 && qso_q <= QSO_SOD_MAX) nxt_state = ST_SOD;
					else if (cmd == CMD_EO) nxt_state = ST_OPEN;
				end

				if (cmd == CMD_FR && nxt_state == ST_SOD) begin
					nxt_warn   = 1'b0;
					nxt_limit  = 1'b0;
					nxt_reason = REASON_NONE;
				end
				rebuild = 1'b1;
			end
			OP_MODE: begin
				nxt_mode = item.mode_value;
			end
			OP_TICK: begin
				if (state_q == ST_OPEN) begin
					if (!mode_sup) begin
						nxt_state  = ST_FRA;
						nxt_reason = REASON_UNSUP;
					end else begin
						case (mode_q[4:0])
							MODE_PROFILE_POS, MODE_HOMING: begin
								if (!item.handler_present) begin
									nxt_reached = 1'b1;
								end else if (!item.handler_ok) begin
									nxt_state  = ST_FRA;
									nxt_reason = REASON_HANDLER;
								end
							end
							MODE_VELOCITY, MODE_PROFILE_VEL, MODE_TORQUE, MODE_INTERP_POS,
							MODE_CSP, MODE_CSV, MODE_CST: begin
								if (item.handler_present && !item.handler_ok) begin
									nxt_state  = ST_FRA;
									nxt_reason = REASON_HANDLER;
								end
							end
							default: begin
								nxt_state  = ST_FRA;
								nxt_reason = REASON_UNSUP;
							end
						endcase
					end
					if (nxt_state == ST_FRA) begin
						nxt_warn    = 1'b1;
						nxt_reached = 1'b0;
						nxt_limit   = 1'b1;
					end
				end
				// fault reaction completes within the same tick
				if (nxt_state == ST_FRA) nxt_state = ST_FLT;
				rebuild = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		case (nxt_state)
			ST_SOD:  state_bits = 7'b1000000;
			ST_RDY:  state_bits = 7'b0110001;
			ST_SWON: state_bits = 7'b0110011;
			ST_OPEN: state_bits = 7'b0110111;
			ST_QS:   state_bits = 7'b0010011;
			ST_FRA:  state_bits = 7'b0011000;
			ST_FLT:  state_bits = 7'b0001000;
			default: state_bits = 7'b0000000;
		endcase
		nxt_status = {4'b0000, nxt_limit, nxt_reached, remote_q, 1'b0, nxt_warn, state_bits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_SOD;
			mode_q         <= '0;
			mode_latched_q <= '0;
			warn_q         <= 1'b0;
			reached_q      <= 1'b0;
			limit_q        <= 1'b0;
			reason_q       <= REASON_NONE;
			status_q       <= STATUS_RESET;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				state_q   <= nxt_state;
				mode_q    <= nxt_mode;
				warn_q    <= nxt_warn;
				reached_q <= nxt_reached;
				limit_q   <= nxt_limit;
				reason_q  <= nxt_reason;
				if (rebuild) begin
					status_q       <= nxt_status;
					mode_latched_q <= mode_q;
				end
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sup_modes_q <= '0;
			qso_q       <= QSO_RESET;
			remote_q    <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_SUPPORTED_MODES: sup_modes_q <= cfg.data;
				CFG_QS_OPTION:       qso_q       <= $signed(cfg.data[QSO_W-1:0]);
				CFG_REMOTE:          remote_q    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status_word  = status_q;
	assign result.mode_shown   = mode_latched_q;
	assign result.drive_state  = state_q;
	assign result.fault_reason = reason_q;
	assign result.fault_active = (state_q == ST_FRA) || (state_q == ST_FLT);

`ifndef SYNTHESIS
	a_no_rest_in_reaction: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_FRA)
		else $error("fault reaction state held across a cycle");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> item.ready)
		else $error("input stalled with no result pending");

	a_mode_write_keeps_status: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.op == OP_MODE) |=> (status_q == $past(status_q)
			&& state_q == $past(state_q)))
		else $error("mode write changed statusword or state");

	a_reason_with_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(reason_q != REASON_NONE) |-> (warn_q && limit_q))
		else $error("fault reason set without warning and limit flags");

	a_sod_bit_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		status_q[6] == (state_q == ST_SOD))
		else $error("statusword switch on disabled bit out of step with state");
`endif

endmodule

`default_nettype wire

// File: dv/drive_power_state_machine_tb.sv
`timescale 1ns / 1ps

module drive_power_state_machine_tb;
	import dpsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 155;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef enum logic [STATE_W-1:0] {
		DS_SOD         = 3'd0,
		DS_READY       = 3'd1,
		DS_SWITCHED_ON = 3'd2,
		DS_OP_ENABLED  = 3'd3,
		DS_QUICK_STOP  = 3'd4,
		DS_FAULT_REACT = 3'd5,
		DS_FAULT       = 3'd6
	} drive_state_e;

	typedef enum logic [2:0] {
		CMD_NONE, CMD_DV, CMD_SD, CMD_SO, CMD_DO, CMD_EO, CMD_QS, CMD_FR
	} drive_cmd_e;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [CW_W-1:0]          cw;
		logic signed [MODE_W-1:0] mode;
		logic                     hp;
		logic                     ok;
	} drive_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]      status_word;
		logic signed [MODE_W-1:0] mode_shown;
		logic [STATE_W-1:0]       drive_state;
		logic [REASON_W-1:0]      fault_reason;
		logic                     fault_active;
	} drive_res_t;

	class power_state_board;
		logic [31:0]              sup_modes;
		logic signed [QSO_W-1:0]  qs_option;
		logic                     remote;
		drive_state_e             dstate;
		logic signed [MODE_W-1:0] mode_reg;
		logic signed [MODE_W-1:0] mode_lat;
		logic                     warn;
		logic                     reached;
		logic                     limit;
		logic [REASON_W-1:0]      reason;
		logic [STATUS_W-1:0]      status;
		drive_res_t               status_due[$];
		int                       mismatches;

		function new();
			sup_modes  = '0;
			qs_option  = QSO_RESET;
			remote     = 1'b1;
			dstate     = DS_SOD;
			mode_reg   = '0;
			mode_lat   = '0;
			warn       = 1'b0;
			reached    = 1'b0;
			limit      = 1'b0;
			reason     = REASON_NONE;
			status     = STATUS_RESET;
			mismatches = 0;
		endfunction

		function int pending();
			return status_due.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_SUPPORTED_MODES: sup_modes = data;
				CFG_QS_OPTION:       qs_option = data[QSO_W-1:0];
				CFG_REMOTE:          remote    = data[0];
				default: ;
			endcase
		endfunction

		function drive_cmd_e decode(logic [CW_W-1:0] cw);
			logic [CW_W-1:0] c;
			c = cw & CW_CMD_MASK;
			if (cw[CW_FAULT_RESET_BIT])
				return CMD_FR;
			case (c)
				CW_DISABLE_VOLTAGE: return CMD_DV;
				CW_SHUTDOWN:        return CMD_SD;
				CW_SWITCH_ON:       return CMD_SO;
				CW_ENABLE_OP:       return CMD_EO;
				CW_QUICK_STOP:      return CMD_QS;
				default:            return CMD_NONE;
			endcase
		endfunction

		function drive_state_e next_state(drive_state_e s, drive_cmd_e cmd);
			case (s)
				DS_SOD: begin
					if (cmd == CMD_SD) return DS_READY;
				end
				DS_READY: begin
					if (cmd == CMD_DV || cmd == CMD_QS) return DS_SOD;
					if (cmd == CMD_SO) return DS_SWITCHED_ON;
				end
				DS_SWITCHED_ON: begin
					if (cmd == CMD_SD) return DS_READY;
					if (cmd == CMD_DV || cmd == CMD_QS) return DS_SOD;
					if (cmd == CMD_EO) return DS_OP_ENABLED;
				end
				DS_OP_ENABLED: begin
					if (cmd == CMD_DO) return DS_SWITCHED_ON;
					if (cmd == CMD_SD) return DS_READY;
					if (cmd == CMD_DV) return DS_SOD;
					if (cmd == CMD_QS) return DS_QUICK_STOP;
				end
				DS_QUICK_STOP: begin
					if (cmd == CMD_DV) return DS_SOD;
					if (cmd == CMD_EO) return DS_OP_ENABLED;
				end
				DS_FAULT: begin
					if (cmd == CMD_FR) return DS_SOD;
				end
				default: ;
			endcase
			return s;
		endfunction

		function void rebuild_status();
			logic [STATUS_W-1:0] w;
			w     = '0;
			w[0]  = dstate inside {DS_READY, DS_SWITCHED_ON, DS_OP_ENABLED, DS_QUICK_STOP};
			w[1]  = dstate inside {DS_SWITCHED_ON, DS_OP_ENABLED, DS_QUICK_STOP};
			w[2]  = (dstate == DS_OP_ENABLED);
			w[3]  = dstate inside {DS_FAULT, DS_FAULT_REACT};
			w[4]  = dstate inside {DS_READY, DS_SWITCHED_ON, DS_OP_ENABLED, DS_QUICK_STOP,
				DS_FAULT_REACT};
			w[5]  = dstate inside {DS_READY, DS_SWITCHED_ON, DS_OP_ENABLED};
			w[6]  = (dstate == DS_SOD);
			w[7]  = warn;
			w[9]  = remote;
			w[10] = reached;
			w[11] = limit;
			status   = w;
			mode_lat = mode_reg;
		endfunction

		function void enter_fault(logic [REASON_W-1:0] why);
			warn    = 1'b1;
			reached = 1'b0;
			limit   = 1'b1;
			reason  = why;
			dstate  = DS_FAULT_REACT;
		endfunction

		function void apply_control(logic [CW_W-1:0] cw);
			drive_cmd_e cmd;
			cmd = decode(cw);
			// 0x07 while enabled means disable operation
			if (dstate == DS_OP_ENABLED && cmd == CMD_SO)
				cmd = CMD_DO;
			dstate = next_state(dstate, cmd);
			if (dstate == DS_QUICK_STOP) begin
				if (qs_option >= 16'sd0 && qs_option <= QSO_SOD_MAX)
					dstate = DS_SOD;
				else if (cmd == CMD_EO)
					dstate = DS_OP_ENABLED;
			end
			if (cmd == CMD_FR && dstate == DS_SOD) begin
				reason = REASON_NONE;
				warn   = 1'b0;
				limit  = 1'b0;
			end
			rebuild_status();
		endfunction

		function void apply_tick(logic hp, logic ok);
			logic [4:0] m;
			logic       sup;
			m = mode_reg[4:0];
			if (dstate == DS_OP_ENABLED) begin
				sup = (mode_reg >= 8'sd0) && (mode_reg < 8'sd32) && sup_modes[m];
				if (!sup) begin
					enter_fault(REASON_UNSUP);
				end else if (m == MODE_PROFILE_POS || m == MODE_HOMING) begin
					if (!hp)
						reached = 1'b1;
					else if (!ok)
						enter_fault(REASON_HANDLER);
				end else if (m inside {MODE_VELOCITY, MODE_PROFILE_VEL, MODE_TORQUE,
						MODE_INTERP_POS, MODE_CSP, MODE_CSV, MODE_CST}) begin
					if (hp && !ok)
						enter_fault(REASON_HANDLER);
				end else begin
					enter_fault(REASON_UNSUP);
				end
			end
			if (dstate == DS_FAULT_REACT)
				dstate = DS_FAULT;
			rebuild_status();
		endfunction

		function void note_request(drive_req_t r);
			drive_res_t e;
			case (r.op)
				OP_CTRL: apply_control(r.cw);
				OP_MODE: mode_reg = r.mode;
				OP_TICK: apply_tick(r.hp, r.ok);
				default: ;
			endcase
			e.status_word  = status;
			e.mode_shown   = mode_lat;
			e.drive_state  = dstate;
			e.fault_reason = reason;
			e.fault_active = (dstate == DS_FAULT) || (dstate == DS_FAULT_REACT);
			status_due.push_back(e);
		endfunction

		function void check_result(drive_res_t got);
			drive_res_t exp;
			logic       bad;
			if (status_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: status %h mode %0d state %0d reason %0d fault %0b",
						got.status_word, got.mode_shown, got.drive_state, got.fault_reason,
						got.fault_active);
				mismatches++;
				return;
			end
			exp = status_due.pop_front();
			bad = (got.status_word !== exp.status_word) || (got.mode_shown !== exp.mode_shown) ||
				(got.drive_state !== exp.drive_state) || (got.fault_reason !== exp.fault_reason) ||
				(got.fault_active !== exp.fault_active);
			if (bad) begin
				if (mismatches < 10) begin
					$display("mismatch at %0t: expected status %h mode %0d state %0d reason %0d fault %0b",
						$realtime, exp.status_word, exp.mode_shown, exp.drive_state,
						exp.fault_reason, exp.fault_active);
					$display("                got status %h mode %0d state %0d reason %0d fault %0b",
						got.status_word, got.mode_shown, got.drive_state, got.fault_reason,
						got.fault_active);
				end
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	dpsm_in_if  in_if();
	dpsm_out_if out_if();
	dpsm_cfg_if cfg_if();

	drive_power_state_machine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_if),
		.result (out_if),
		.cfg    (cfg_if)
	);

	power_state_board sb;
	int               send_idle_pct;
	int               recv_stall_pct;
	int               hold_reqs;
	int               holds_taken;
	int               hold_left;
	int               reqs_sent;
	int               quiet_cycles;
	logic             progress;
	drive_req_t       seen_req;
	drive_res_t       seen_res;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random stalls plus one long hold-off on request
	initial begin
		out_if.ready = 1'b0;
		hold_left    = 0;
		holds_taken  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left == 0 && holds_taken != hold_reqs) begin
				hold_left = HOLD_CYCLES;
				holds_taken++;
			end
			if (hold_left > 0) begin
				out_if.ready = 1'b0;
				hold_left--;
			end else begin
				out_if.ready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// monitor, scoreboard hookup and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (out_if.valid && out_if.ready) begin
				seen_res.status_word  = out_if.status_word;
				seen_res.mode_shown   = out_if.mode_shown;
				seen_res.drive_state  = out_if.drive_state;
				seen_res.fault_reason = out_if.fault_reason;
				seen_res.fault_active = out_if.fault_active;
				sb.check_result(seen_res);
				progress = 1'b1;
			end
			if (cfg_if.valid && cfg_if.ready) begin
				sb.write_reg(cfg_if.index, cfg_if.data);
				progress = 1'b1;
			end
			if (in_if.valid && in_if.ready) begin
				seen_req.op   = in_if.op;
				seen_req.cw   = in_if.control_value;
				seen_req.mode = in_if.mode_value;
				seen_req.hp   = in_if.handler_present;
				seen_req.ok   = in_if.handler_ok;
				sb.note_request(seen_req);
				progress = 1'b1;
			end
			quiet_cycles = progress ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("drive_power_state_machine_tb: errors");
				$finish;
			end
		end else begin
			quiet_cycles = 0;
		end
	end

	// all drive tasks start and end at a falling edge
	task automatic send_req(logic [OP_W-1:0] op, logic [CW_W-1:0] cw,
			logic signed [MODE_W-1:0] mode, logic hp, logic ok);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_if.valid = 1'b0;
			@(negedge clk);
		end
		in_if.valid           = 1'b1;
		in_if.op              = op;
		in_if.control_value   = cw;
		in_if.mode_value      = mode;
		in_if.handler_present = hp;
		in_if.handler_ok      = ok;
		do @(posedge clk); while (!in_if.ready);
		if (op != OP_UNUSED)
			reqs_sent++;
		@(negedge clk);
	endtask

	task automatic send_ctrl(logic [CW_W-1:0] cw);
		send_req(OP_CTRL, cw, MODE_W'($urandom), 1'($urandom), 1'($urandom));
	endtask

	task automatic send_mode(logic signed [MODE_W-1:0] mode);
		send_req(OP_MODE, CW_W'($urandom), mode, 1'($urandom), 1'($urandom));
	endtask

	task automatic send_tick(logic hp, logic ok);
		send_req(OP_TICK, CW_W'($urandom), MODE_W'($urandom), hp, ok);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = data;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_config(logic [31:0] modes, logic signed [QSO_W-1:0] qso, logic rem);
		cfg_write(CFG_SUPPORTED_MODES, modes);
		cfg_write(CFG_QS_OPTION, {{(CFG_DATA_W-QSO_W){qso[QSO_W-1]}}, qso});
		cfg_write(CFG_REMOTE, {{(CFG_DATA_W-1){1'b0}}, rem});
	endtask

	// wait until every request has its result, then leave a margin
	task automatic drain();
		in_if.valid = 1'b0;
		while (sb.pending() != 0 || hold_left != 0 || holds_taken != hold_reqs)
			@(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	// bits outside the command mask (4..6, 8..15)
	function automatic logic [CW_W-1:0] cw_noise();
		return CW_W'($urandom) & 16'hFF70;
	endfunction

	function automatic logic signed [MODE_W-1:0] pick_mode();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return MODE_W'($urandom_range(0, 11));
		else if (p < 85)
			return ($urandom_range(0, 1) == 0) ? -8'sd1 : MODE_W'(32 - $urandom_range(0, 1));
		return MODE_W'($urandom);
	endfunction

	task automatic inner_step();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65) begin
			send_tick(1'($urandom), $urandom_range(0, 3) != 0);
		end else if (p < 88) begin
			case ($urandom_range(0, 4))
				0: send_ctrl(CW_QUICK_STOP | cw_noise());
				1: send_ctrl(CW_SWITCH_ON | cw_noise());
				2: send_ctrl(CW_ENABLE_OP | cw_noise());
				3: send_ctrl(CW_SHUTDOWN | cw_noise());
				default: send_ctrl(CW_DISABLE_VOLTAGE | cw_noise());
			endcase
		end else begin
			send_mode(pick_mode());
		end
	endtask

	task automatic random_traffic(int n);
		int target;
		target = reqs_sent + n;
		while (reqs_sent < target) begin
			if ($urandom_range(0, 99) < 70) begin
				// bring the drive up to operation enabled, then work it
				if ($urandom_range(0, 1) == 0)
					send_ctrl(16'h0080 | CW_W'($urandom));
				send_ctrl(CW_SHUTDOWN | cw_noise());
				send_ctrl(CW_SWITCH_ON | cw_noise());
				send_ctrl(CW_ENABLE_OP | cw_noise());
				if ($urandom_range(0, 3) != 0)
					send_mode(pick_mode());
				repeat ($urandom_range(1, 6))
					inner_step();
			end else begin
				send_req(OP_W'($urandom), CW_W'($urandom), MODE_W'($urandom), 1'($urandom),
					1'($urandom));
			end
		end
	endtask

	initial begin
		logic [31:0]             modes;
		logic signed [QSO_W-1:0] qso;

		arst_n                = 1'b0;
		in_if.valid           = 1'b0;
		in_if.op              = OP_CTRL;
		in_if.control_value   = '0;
		in_if.mode_value      = '0;
		in_if.handler_present = 1'b0;
		in_if.handler_ok      = 1'b0;
		cfg_if.valid          = 1'b0;
		cfg_if.index          = CFG_SUPPORTED_MODES;
		cfg_if.data           = '0;
		send_idle_pct         = 0;
		recv_stall_pct        = 0;
		hold_reqs             = 0;
		reqs_sent             = 0;
		sb                    = new();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_config(32'hFFFF_FFFF, 16'sd2, 1'b0);
		send_ctrl(16'hFFFF);                    // fault reset while already disabled
		send_ctrl(CW_SHUTDOWN);
		send_ctrl(CW_SWITCH_ON);
		send_ctrl(CW_ENABLE_OP);
		send_mode(8'sd1);
		send_tick(1'b0, 1'b1);                  // no position handler: target reached
		send_ctrl(CW_SWITCH_ON);                // disable operation
		send_ctrl(CW_ENABLE_OP);
		send_ctrl(CW_QUICK_STOP);               // option 2 ends in switch on disabled
		send_ctrl(CW_SHUTDOWN);
		send_ctrl(CW_SWITCH_ON);
		send_ctrl(CW_ENABLE_OP);
		send_mode(8'sd8);
		send_tick(1'b1, 1'b0);                  // handler failure
		send_ctrl(CW_ENABLE_OP);                // no transition out of fault
		send_ctrl(16'h0080);
		send_mode(-8'sd128);
		send_tick(1'b1, 1'b1);
		send_req(OP_UNUSED, 16'hFFFF, -8'sd1, 1'b1, 1'b1);
		send_mode(8'sd127);
		send_ctrl(CW_DISABLE_VOLTAGE);
		drain();
		set_config(32'h0000_0002, -16'sd32768, 1'b1);
		send_ctrl(CW_SHUTDOWN);
		send_ctrl(CW_SWITCH_ON);
		send_ctrl(CW_ENABLE_OP);
		send_ctrl(CW_QUICK_STOP);               // negative option keeps quick stop
		send_ctrl(CW_ENABLE_OP);
		send_tick(1'b1, 1'b1);                  // mode 127 unsupported

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			case (ph)
				0: begin modes = 32'hFFFF_FFFF;         qso = -16'sd32768; end
				1: begin modes = 32'h0000_07DE;         qso = 16'sd32767;  end
				2: begin modes = 32'h0000_0000;         qso = 16'sd0;      end
				3: begin modes = $urandom;              qso = 16'sd3;      end
				4: begin modes = 32'hFFFF_FFFF;         qso = -16'sd1;     end
				5: begin modes = $urandom;              qso = 16'sd1;      end
				6: begin modes = 32'h0000_07DE | $urandom; qso = 16'sd2;   end
				default: begin modes = 32'h8000_0001;   qso = QSO_W'($urandom); end
			endcase
			set_config(modes, qso, ph[0]);
			if (ph == 1)
				hold_reqs++;
			random_traffic(PHASE_ITEMS);
		end

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("drive_power_state_machine_tb: clean");
		else
			$display("drive_power_state_machine_tb: errors");
		$finish;
	end

endmodule
